FILE: design/rqs_pkg.sv
// Shared types and codes for the ready queue scheduler.
package rqs_pkg;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_SELECT = 1'b1;

  localparam logic [1:0] POL_FIFO = 2'd0;
  localparam logic [1:0] POL_SJF  = 2'd1;
  localparam logic [1:0] POL_PRIO = 2'd2;

  typedef struct packed {
    logic       func;
    logic [7:0] proc_id;
    logic [7:0] job_size;
    logic [7:0] prio_level;
  } in_item_t;

  typedef struct packed {
    logic       found;
    logic [7:0] out_id;
    logic [7:0] out_size;
    logic [7:0] out_prio;
    logic       dropped;
    logic [4:0] occupancy;
  } out_item_t;

  typedef struct packed {
    logic [7:0] proc_id;
    logic [7:0] job_size;
    logic [7:0] prio_level;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_DRAIN,
    ST_SHIFT_INIT,
    ST_SHIFT,
    ST_SHIFT_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic ins_item;
    logic sel_empty;
    logic scan_start;
    logic scan_rd;
    logic shift_start;
    logic shift_rd;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic scan_last;
    logic shift_none;
    logic shift_last;
  } stat_t;

endpackage

FILE: design/ready_queue_scheduler_core.sv
// Ready queue scheduler top level: ordered process list with FIFO, SJF and priority pick.
//
// Input: an item (insert or select) is taken when start is high and busy is low.
// Output: each item gives one result, shown on out_data for exactly one cycle
//   while out_valid is high; the receiver cannot stall it and must take it then.
// Config: cfg_data (policy) is written when cfg_valid and cfg_ready are high;
//   cfg_ready is low while an item is in progress.
// Insert, and select from an empty list, finish in one cycle: the result shows
//   in the cycle after acceptance and a new item may be taken in that same cycle.
// A select scans L entries (L = list count for SJF and priority, 1 for FIFO)
//   through the list memory's single read port, one entry a cycle, then moves up
//   the S entries behind the chosen one, one per cycle through the same port.
//   busy stays high through the scan, scan drain, shift set-up, any shifts and shift
//   drain (only when S > 0) and finish steps; the result shows in the cycle busy drops.
// Reset (rst_n low, synchronous) empties the list and sets the policy to FIFO.
module ready_queue_scheduler_core #(
  parameter int LIST_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  rqs_pkg::in_item_t  in_data,
  output logic               out_valid,
  output rqs_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_data
);
  import rqs_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = !busy;

  rqs_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .func  (in_data.func),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  rqs_dpath #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // An accepted select either starts a scan or reports an empty list next cycle.
  a_select_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_data.func == FUNC_SELECT)) |=> (busy || out_valid))
    else $error("select item neither scanned nor answered");

  // An accepted insert answers next cycle with no entry returned.
  a_insert_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_data.func == FUNC_INSERT)) |=> (out_valid && !out_data.found))
    else $error("insert item result missing or wrong");

  // A returned entry only comes out of a select that held busy high.
  a_found_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.found) |-> $past(busy))
    else $error("entry returned without a scan");

  // Controller issues at most one datapath command at a time.
  a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.ins_item, cmd.sel_empty, cmd.scan_start, cmd.scan_rd,
              cmd.shift_start, cmd.shift_rd, cmd.finish}))
    else $error("conflicting datapath commands");

endmodule

FILE: design/rqs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rqs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: design/rqs_ctrl.sv
// Controller state machine: sequences insert, scan, shift and finish steps.
module rqs_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic           func,
  input  rqs_pkg::stat_t stat,
  output logic           busy,
  output rqs_pkg::cmd_t  cmd
);
  import rqs_pkg::*;

  state_t state_r, state_nxt;
  logic   accept;

  assign accept = start && (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (func == FUNC_SELECT) && !stat.empty) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat.scan_last) begin
          state_nxt = ST_SCAN_DRAIN;
        end
      end
      ST_SCAN_DRAIN: state_nxt = ST_SHIFT_INIT;
      ST_SHIFT_INIT: begin
        state_nxt = stat.shift_none ? ST_FINISH : ST_SHIFT;
      end
      ST_SHIFT: begin
        if (stat.shift_last) begin
          state_nxt = ST_SHIFT_DRAIN;
        end
      end
      ST_SHIFT_DRAIN: state_nxt = ST_FINISH;
      ST_FINISH: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    busy            = (state_r != ST_IDLE);
    cmd.ins_item    = accept && (func == FUNC_INSERT);
    cmd.sel_empty   = accept && (func == FUNC_SELECT) && stat.empty;
    cmd.scan_start  = accept && (func == FUNC_SELECT) && !stat.empty;
    cmd.scan_rd     = (state_r == ST_SCAN);
    cmd.shift_start = (state_r == ST_SHIFT_INIT);
    cmd.shift_rd    = (state_r == ST_SHIFT);
    cmd.finish      = (state_r == ST_FINISH);
  end

endmodule

FILE: design/rqs_dpath.sv
// Datapath: list storage, count, scan pointer, best-entry tracking, result register.
module rqs_dpath #(
  parameter int LIST_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rqs_pkg::in_item_t  in_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_data,
  input  rqs_pkg::cmd_t      cmd,
  output rqs_pkg::stat_t     stat,
  output logic               out_valid,
  output rqs_pkg::out_item_t out_data
);
  import rqs_pkg::*;

  localparam int AW = $clog2(LIST_DEPTH);
  localparam int CW = $clog2(LIST_DEPTH + 1);

  logic [1:0]    policy_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] ptr_r, ptr_nxt;
  logic          scan_vld_r, shift_vld_r;
  logic [AW-1:0] rd_addr_r;
  logic          have_r;
  logic [7:0]    best_key_r;
  logic [AW-1:0] best_idx_r;
  entry_t        best_ent_r;
  logic          out_valid_r;
  out_item_t     out_r, out_nxt;

  logic          keyed;
  logic [CW-1:0] scan_lim;
  logic [CW-1:0] best_next;
  logic [7:0]    key;
  logic          take;
  logic          ins_ok;
  entry_t        rd_ent, wr_ent;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;

  assign keyed     = (policy_r == POL_SJF) || (policy_r == POL_PRIO);
  assign scan_lim  = keyed ? cnt_r : CW'(1);
  assign best_next = CW'(best_idx_r) + CW'(1);

  assign stat.full       = (cnt_r == CW'(LIST_DEPTH));
  assign stat.empty      = (cnt_r == '0);
  assign stat.scan_last  = ((ptr_r + CW'(1)) == scan_lim);
  assign stat.shift_none = (best_next >= cnt_r);
  assign stat.shift_last = ((ptr_r + CW'(1)) == cnt_r);

  assign ins_ok = cmd.ins_item && !stat.full;

  assign key  = (policy_r == POL_SJF) ? rd_ent.job_size : rd_ent.prio_level;
  assign take = scan_vld_r && (!have_r || (key < best_key_r));

  // Shifted entries move up one place: write back one slot below where they were read.
  assign wr_ent.proc_id    = in_data.proc_id;
  assign wr_ent.job_size   = in_data.job_size;
  assign wr_ent.prio_level = in_data.prio_level;
  assign ram_we    = ins_ok || shift_vld_r;
  assign ram_waddr = shift_vld_r ? (rd_addr_r - AW'(1)) : cnt_r[AW-1:0];

  rqs_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (LIST_DEPTH)
  ) u_list (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (shift_vld_r ? rd_ent : wr_ent),
    .raddr (ptr_r[AW-1:0]),
    .rdata (rd_ent)
  );

  always_comb begin
    cnt_nxt = cnt_r;
    if (ins_ok) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (cmd.finish) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_comb begin
    ptr_nxt = ptr_r;
    if (cmd.scan_start) begin
      ptr_nxt = '0;
    end else if (cmd.shift_start) begin
      ptr_nxt = best_next;
    end else if (cmd.scan_rd || cmd.shift_rd) begin
      ptr_nxt = ptr_r + CW'(1);
    end
  end

  always_comb begin
    out_nxt = '0;
    if (cmd.ins_item) begin
      out_nxt.dropped   = stat.full;
      out_nxt.occupancy = 5'(cnt_nxt);
    end else if (cmd.sel_empty) begin
      out_nxt.occupancy = 5'(cnt_r);
    end else if (cmd.finish) begin
      out_nxt.found     = 1'b1;
      out_nxt.out_id    = best_ent_r.proc_id;
      out_nxt.out_size  = best_ent_r.job_size;
      out_nxt.out_prio  = best_ent_r.prio_level;
      out_nxt.occupancy = 5'(cnt_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r    <= POL_FIFO;
      cnt_r       <= '0;
      ptr_r       <= '0;
      scan_vld_r  <= 1'b0;
      shift_vld_r <= 1'b0;
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        policy_r <= cfg_data;
      end
      cnt_r       <= cnt_nxt;
      ptr_r       <= ptr_nxt;
      scan_vld_r  <= cmd.scan_rd;
      shift_vld_r <= cmd.shift_rd;
      if (cmd.scan_start) begin
        have_r <= 1'b0;
      end else if (take) begin
        have_r <= 1'b1;
      end
      out_valid_r <= cmd.ins_item || cmd.sel_empty || cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_r <= ptr_r[AW-1:0];
    if (take) begin
      best_key_r <= key;
      best_idx_r <= rd_addr_r;
      best_ent_r <= rd_ent;
    end
    if (cmd.ins_item || cmd.sel_empty || cmd.finish) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
